@@ sv/bspq_pkg.sv @@
// bspq_pkg: shared codes and types for the bounded stable priority queue
// used by the cell, the top level and the port checker; depends on nothing
package bspq_pkg;

   // request codes; any other code is a status query
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_QUERY   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   // width of the capacity limit register
   localparam int LIMIT_BITS = 5;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

   // per-cell control from the row controller
   typedef struct packed {
      logic enq;
      logic deq;
      logic occupied;
   } cell_ctl_type;

endpackage

@@ sv/bspq_cell.sv @@
// bspq_cell: one slot of the sorted row, holds a word and its biased key
// depends on bspq_pkg (cell_ctl_type)
module bspq_cell #(
   parameter int VALUE_BITS = 32,
   parameter int KEY_BITS   = 8
) (
   input  logic                      clock,
   input  bspq_pkg::cell_ctl_type    ctl,
   input  logic [VALUE_BITS-1:0]     new_value,
   input  logic [KEY_BITS-1:0]       new_key,
   input  logic [VALUE_BITS-1:0]     prev_value,
   input  logic [KEY_BITS-1:0]       prev_key,
   input  logic                      prev_displace,
   input  logic [VALUE_BITS-1:0]     next_value,
   input  logic [KEY_BITS-1:0]       next_key,
   output logic                      displace,
   output logic [VALUE_BITS-1:0]     value_q,
   output logic [KEY_BITS-1:0]       key_q,
   output logic [VALUE_BITS-1:0]     nxt_value,
   output logic [KEY_BITS-1:0]       nxt_key
);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic [KEY_BITS-1:0]   key_ff;
   logic [KEY_BITS-1:0]   key_in;

   // new word goes below every held word of equal or higher key
   assign displace = !(ctl.occupied && (key_ff >= new_key));

   always_comb begin
      value_in = value_ff;
      key_in   = key_ff;
      if (ctl.enq && displace) begin
         if (prev_displace) begin
            value_in = prev_value;
            key_in   = prev_key;
         end else begin
            value_in = new_value;
            key_in   = new_key;
         end
      end else if (ctl.deq) begin
         value_in = next_value;
         key_in   = next_key;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      key_ff   <= key_in;
   end

   assign value_q   = value_ff;
   assign key_q     = key_ff;
   assign nxt_value = value_in;
   assign nxt_key   = key_in;

endmodule

@@ sv/bounded_stable_priority_queue_unit.sv @@
// bounded_stable_priority_queue_unit: sorted row of cells with count and limit control
// depends on bspq_pkg and bspq_cell
//
//   channel | ports            | direction | word
//   req     | req_valid/stall  | in        | req_type, req_item_value, req_item_priority
//   rsp     | rsp_valid/stall  | out       | front, flags, count, error code
//   csr     | csr_wr_en/data   | in        | capacity limit, no read-back
//
// for every request the whole row compares against the new key
// in parallel and each cell loads from its neighbor, the new word or itself.
// the response is registered and shows in the cycle after acceptance.
// one request per cycle; req_stall is high only while a response waits under rsp_stall.
// synchronous reset empties the queue and sets the limit to 16; cell contents stay.
module bounded_stable_priority_queue_unit #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int VALUE_BITS    = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_type,
   input  logic signed [VALUE_BITS-1:0]           req_item_value,
   input  logic signed [PRIORITY_BITS-1:0]        req_item_priority,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [VALUE_BITS-1:0]           rsp_front_value,
   output logic signed [PRIORITY_BITS-1:0]        rsp_front_priority,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_is_full,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_entry_count,
   output logic [1:0]                             rsp_error_code,
   input  logic                                   csr_wr_en,
   input  logic [bspq_pkg::LIMIT_BITS-1:0]        csr_wr_data
);

   localparam int CountBits = $clog2(CAPACITY + 1);
   localparam int CmpBits   = (CountBits > bspq_pkg::LIMIT_BITS) ?
                              CountBits : bspq_pkg::LIMIT_BITS;

   logic [bspq_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [CountBits-1:0]            count_ff;
   logic [CountBits-1:0]            count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;

   logic [VALUE_BITS-1:0]    front_value_ff;
   logic [VALUE_BITS-1:0]    front_value_in;
   logic [PRIORITY_BITS-1:0] front_prio_ff;
   logic [PRIORITY_BITS-1:0] front_prio_in;
   logic                     empty_ff;
   logic                     empty_in;
   logic                     full_ff;
   logic                     full_in;
   logic [CountBits-1:0]     rsp_count_ff;
   logic [1:0]               err_ff;
   logic [1:0]               err_in;

   logic                     req_accept;
   logic [CmpBits-1:0]       limit_ext;
   logic [CmpBits-1:0]       eff_limit;
   logic                     full_now;
   logic                     do_enq;
   logic                     do_deq;
   logic [PRIORITY_BITS-1:0] new_key;

   logic [VALUE_BITS-1:0]    cell_value [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_key   [CAPACITY];
   logic [VALUE_BITS-1:0]    cell_nxt_value [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_nxt_key   [CAPACITY];
   logic                     cell_displace  [CAPACITY];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // limit saturates at the row length
   assign limit_ext = CmpBits'(limit_ff);
   assign eff_limit = (limit_ext > CmpBits'(CAPACITY)) ? CmpBits'(CAPACITY) : limit_ext;
   assign full_now  = CmpBits'(count_ff) >= eff_limit;

   // biased key: sign bit flipped so unsigned compare gives signed order
   assign new_key = {~req_item_priority[PRIORITY_BITS-1],
                     req_item_priority[PRIORITY_BITS-2:0]};

   always_comb begin
      do_enq = 1'b0;
      do_deq = 1'b0;
      err_in = bspq_pkg::ERR_OK;
      case (req_type)
         bspq_pkg::REQ_ENQUEUE: begin
            if (full_now) err_in = bspq_pkg::ERR_FULL;
            else          do_enq = req_accept;
         end
         bspq_pkg::REQ_DEQUEUE: begin
            if (count_ff == '0) err_in = bspq_pkg::ERR_EMPTY;
            else                do_deq = req_accept;
         end
         default: begin
            err_in = bspq_pkg::ERR_OK;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_enq)      count_in = count_ff + CountBits'(1);
      else if (do_deq) count_in = count_ff - CountBits'(1);
   end

   generate
      for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
         bspq_pkg::cell_ctl_type   ctl;
         logic [VALUE_BITS-1:0]    prev_value;
         logic [PRIORITY_BITS-1:0] prev_key;
         logic                     prev_displace;
         logic [VALUE_BITS-1:0]    next_value;
         logic [PRIORITY_BITS-1:0] next_key;

         assign ctl.enq      = do_enq;
         assign ctl.deq      = do_deq;
         assign ctl.occupied = count_ff > CountBits'(gi);

         if (gi == 0) begin : g_head
            assign prev_value    = req_item_value;
            assign prev_key      = new_key;
            assign prev_displace = 1'b0;
         end else begin : g_body
            assign prev_value    = cell_value[gi-1];
            assign prev_key      = cell_key[gi-1];
            assign prev_displace = cell_displace[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign next_value = cell_value[gi];
            assign next_key   = cell_key[gi];
         end else begin : g_link
            assign next_value = cell_value[gi+1];
            assign next_key   = cell_key[gi+1];
         end

         bspq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .KEY_BITS   (PRIORITY_BITS)
         ) u_cell (
            .clock         (clock),
            .ctl           (ctl),
            .new_value     (req_item_value),
            .new_key       (new_key),
            .prev_value    (prev_value),
            .prev_key      (prev_key),
            .prev_displace (prev_displace),
            .next_value    (next_value),
            .next_key      (next_key),
            .displace      (cell_displace[gi]),
            .value_q       (cell_value[gi]),
            .key_q         (cell_key[gi]),
            .nxt_value     (cell_nxt_value[gi]),
            .nxt_key       (cell_nxt_key[gi])
         );
      end
   endgenerate

   // response fields reflect the state after the request
   always_comb begin
      empty_in       = (count_in == '0);
      full_in        = CmpBits'(count_in) >= eff_limit;
      front_value_in = '0;
      front_prio_in  = '0;
      if (!empty_in) begin
         front_value_in = cell_nxt_value[0];
         front_prio_in  = {~cell_nxt_key[0][PRIORITY_BITS-1],
                           cell_nxt_key[0][PRIORITY_BITS-2:0]};
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= bspq_pkg::LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         front_value_ff <= front_value_in;
         front_prio_ff  <= front_prio_in;
         empty_ff       <= empty_in;
         full_ff        <= full_in;
         rsp_count_ff   <= count_in;
         err_ff         <= err_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_front_value    = front_value_ff;
   assign rsp_front_priority = front_prio_ff;
   assign rsp_is_empty       = empty_ff;
   assign rsp_is_full        = full_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_error_code     = err_ff;

endmodule

@@ sv/bspq_check.sv @@
// bspq_check: port-level checks on the response channel of the queue
// depends on bspq_pkg; bound to bounded_stable_priority_queue_unit
module bspq_check #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int VALUE_BITS    = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [VALUE_BITS-1:0]             rsp_front_value,
   input logic [PRIORITY_BITS-1:0]          rsp_front_priority,
   input logic                              rsp_is_empty,
   input logic                              rsp_is_full,
   input logic [$clog2(CAPACITY+1)-1:0]     rsp_entry_count,
   input logic [1:0]                        rsp_error_code
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_front_value) &&
      $stable(rsp_entry_count) && $stable(rsp_error_code))
      else $error("response changed while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_front_value == '0) && (rsp_front_priority == '0))
      else $error("front not zero on empty queue");

   a_full_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == bspq_pkg::ERR_FULL) |-> rsp_is_full)
      else $error("enqueue refused while not full");

   a_empty_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == bspq_pkg::ERR_EMPTY) |-> rsp_is_empty)
      else $error("dequeue refused while not empty");

endmodule

bind bounded_stable_priority_queue_unit bspq_check #(
   .CAPACITY      (CAPACITY),
   .PRIORITY_BITS (PRIORITY_BITS),
   .VALUE_BITS    (VALUE_BITS)
) u_bspq_check (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_front_value    (rsp_front_value),
   .rsp_front_priority (rsp_front_priority),
   .rsp_is_empty       (rsp_is_empty),
   .rsp_is_full        (rsp_is_full),
   .rsp_entry_count    (rsp_entry_count),
   .rsp_error_code     (rsp_error_code)
);
